// ===== rtl/mcsf_pkg.sv =====
package mcsf_pkg;

    // Fixed field widths
    localparam int CUR_W      = 21;
    localparam int VOUT_W     = 20;
    localparam int GAIN_W     = 16;
    localparam int MASK_W     = 3;
    localparam int RAIL_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Output limits
    localparam int CUR_MAX_I  = 1048575;
    localparam int CUR_MIN_I  = -1048576;
    localparam int VOUT_MAX_I = 1048575;

    // Midscale offset, 2048.0 in Q.4
    localparam int MIDSCALE_Q4 = 32768;

    // Sign mask bits
    localparam int SIGN_U   = 0;
    localparam int SIGN_V   = 1;
    localparam int SIGN_BUS = 2;

    // Register reset values
    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = 16'd256;
    localparam logic [MASK_W-1:0] SIGN_MASK_RST    = 3'd0;
    localparam logic [GAIN_W-1:0] VBUS_GAIN_RST    = 16'd256;
    localparam logic [GAIN_W-1:0] LPF_ALPHA_RST    = 16'd3277;
    localparam logic [RAIL_W-1:0] RAIL_LOW_RST     = 12'd16;
    localparam logic [RAIL_W-1:0] RAIL_HIGH_RST    = 12'd4079;
    localparam logic [RAIL_W-1:0] OFFSET_MIN_RST   = 12'd1800;
    localparam logic [RAIL_W-1:0] OFFSET_MAX_RST   = 12'd2300;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURRENT_GAIN = 3'd0,
        REG_SIGN_MASK    = 3'd1,
        REG_VBUS_GAIN    = 3'd2,
        REG_LPF_ALPHA    = 3'd3,
        REG_RAIL_LOW     = 3'd4,
        REG_RAIL_HIGH    = 3'd5,
        REG_OFFSET_MIN   = 3'd6,
        REG_OFFSET_MAX   = 3'd7
    } cfg_reg_t;

    // Step strobes from the sequencer to the lanes and the filter
    typedef struct packed {
        logic cmd;
        logic mul;
        logic rnd;
        logic filt;
        logic cal_done;
    } ctrl_t;

    // Control and flags into the merging stage
    typedef struct packed {
        logic load;
        logic cmd;
        logic cal_done;
        logic cal_err;
        logic sat;
    } merge_ctrl_t;

endpackage

// ===== rtl/mcsf_cur_lane.sv =====
module mcsf_cur_lane #(
    parameter int ADC_BITS = 12,
    parameter int CAL_LOG2 = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcsf_pkg::ctrl_t                     ctrl,
    input  logic [ADC_BITS-1:0]                 code,
    input  logic                                negate,
    input  logic [mcsf_pkg::GAIN_W-1:0]         gain,
    input  logic [mcsf_pkg::RAIL_W-1:0]         offset_min,
    input  logic [mcsf_pkg::RAIL_W-1:0]         offset_max,
    output logic signed [mcsf_pkg::CUR_W-1:0]   current,
    output logic                                win_err
);
    import mcsf_pkg::*;

    localparam int OFS_W  = ADC_BITS + 4;
    localparam int SUM_W  = ADC_BITS + CAL_LOG2;
    localparam int AVG_W  = SUM_W + 5;
    localparam int DIFF_W = ADC_BITS + 5;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam int HALF   = (1 << CAL_LOG2) >> 1;
    localparam int CMP_W  = (OFS_W > RAIL_W + 4) ? OFS_W : RAIL_W + 4;

    localparam logic [OFS_W-1:0]         OFS_RST  = OFS_W'(MIDSCALE_Q4);
    localparam logic signed [RND_W-1:0]  RND_HALF = RND_W'(2048);
    localparam logic signed [RND_W-1:0]  RND_HI   = RND_W'(CUR_MAX_I);
    localparam logic signed [RND_W-1:0]  RND_LO   = RND_W'(CUR_MIN_I);
    localparam logic signed [CUR_W-1:0]  OUT_HI   = CUR_W'(CUR_MAX_I);
    localparam logic signed [CUR_W-1:0]  OUT_LO   = CUR_W'(CUR_MIN_I);

    logic [SUM_W-1:0]         sum_reg;
    logic [OFS_W-1:0]         offset_reg;
    logic                     err_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CUR_W-1:0]  cur_reg;

    logic [SUM_W-1:0]         sum_add;
    logic [AVG_W-1:0]         avg_sum;
    logic [AVG_W-1:0]         avg_full;
    logic [OFS_W-1:0]         avg;
    logic                     outside;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] sdiff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [RND_W-1:0]  rnd;
    logic signed [CUR_W-1:0]  cur_next;

    // Accumulate calibration codes
    assign sum_add = sum_reg + SUM_W'(code);

    // Average with round half up, then check against the window
    assign avg_sum  = {1'b0, sum_reg, 4'b0} + AVG_W'(HALF);
    assign avg_full = avg_sum >> CAL_LOG2;
    assign avg      = avg_full[OFS_W-1:0];
    assign outside  = (CMP_W'(avg) < CMP_W'({offset_min, 4'b0}))
                   || (CMP_W'(avg) > CMP_W'({offset_max, 4'b0}));

    // Remove offset, apply sign and gain
    assign diff      = $signed({1'b0, code, 4'b0}) - $signed({1'b0, offset_reg});
    assign sdiff     = negate ? -diff : diff;
    assign prod_next = sdiff * $signed({1'b0, gain});

    // Round to milliamps and clamp
    assign rnd = (RND_W'(prod_reg) + RND_HALF) >>> 12;

    always_comb
    begin
        if (rnd > RND_HI)
        begin
            cur_next = OUT_HI;
        end
        else if (rnd < RND_LO)
        begin
            cur_next = OUT_LO;
        end
        else
        begin
            cur_next = rnd[CUR_W-1:0];
        end
    end

    // Calibration state: sums, offset and window flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= OFS_RST;
            err_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.mul && ctrl.cmd)
            begin
                sum_reg <= sum_add;
            end
            if (ctrl.rnd && ctrl.cal_done)
            begin
                offset_reg <= avg;
                err_reg    <= outside;
                sum_reg    <= '0;
            end
        end
    end

    // Scaling datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.rnd)
        begin
            cur_reg <= cur_next;
        end
    end

    assign current = cur_reg;
    assign win_err = err_reg;

endmodule

// ===== rtl/mcsf_vbus_filt.sv =====
module mcsf_vbus_filt #(
    parameter int ADC_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mcsf_pkg::ctrl_t              ctrl,
    input  logic [ADC_BITS-1:0]          code,
    input  logic [mcsf_pkg::GAIN_W-1:0]  vbus_gain,
    input  logic [mcsf_pkg::GAIN_W-1:0]  lpf_alpha,
    output logic [mcsf_pkg::VOUT_W-1:0]  vbus_out
);
    import mcsf_pkg::*;

    localparam int FW    = ADC_BITS + 16;
    localparam int D_W   = FW + 1;
    localparam int DP_W  = D_W + GAIN_W + 1;
    localparam int ACC_W = DP_W + 1;
    localparam int VW    = (FW + 1 > VOUT_W + 1) ? FW + 1 : VOUT_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] FMAX     = ACC_W'({FW{1'b1}});
    localparam logic [VW-1:0]           V_HALF   = VW'(128);
    localparam logic [VW-1:0]           V_MAX    = VW'(VOUT_MAX_I);

    logic [FW-1:0]           x_reg;
    logic signed [DP_W-1:0]  dp_reg;
    logic [FW-1:0]           state_reg;

    logic [FW-1:0]           x_next;
    logic signed [D_W-1:0]   d;
    logic signed [DP_W-1:0]  dp_next;
    logic signed [ACC_W-1:0] step;
    logic signed [ACC_W-1:0] sum;
    logic [FW-1:0]           state_next;
    logic [VW-1:0]           v_round;

    // Scale to millivolts, Q.8
    assign x_next = code * vbus_gain;

    // Weighted difference to the filter state
    assign d       = $signed({1'b0, x_reg}) - $signed({1'b0, state_reg});
    assign dp_next = d * $signed({1'b0, lpf_alpha});

    // Round the step and clamp the new state
    assign step = (ACC_W'(dp_reg) + ACC_HALF) >>> 16;
    assign sum  = ACC_W'($signed({1'b0, state_reg})) + step;

    always_comb
    begin
        if (sum < 0)
        begin
            state_next = '0;
        end
        else if (sum > FMAX)
        begin
            state_next = '1;
        end
        else
        begin
            state_next = sum[FW-1:0];
        end
    end

    // Filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (ctrl.filt && !ctrl.cmd)
        begin
            state_reg <= state_next;
        end
    end

    // Product pipeline
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            x_reg <= x_next;
        end
        if (ctrl.rnd)
        begin
            dp_reg <= dp_next;
        end
    end

    // Round to millivolts and clamp
    assign v_round  = (VW'(state_reg) + V_HALF) >> 8;
    assign vbus_out = (v_round > V_MAX) ? V_MAX[VOUT_W-1:0] : v_round[VOUT_W-1:0];

endmodule

// ===== rtl/mcsf_merge.sv =====
module mcsf_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mcsf_pkg::merge_ctrl_t              mctl,
    input  logic signed [mcsf_pkg::CUR_W-1:0]  cur_u,
    input  logic signed [mcsf_pkg::CUR_W-1:0]  cur_v,
    input  logic signed [mcsf_pkg::CUR_W-1:0]  cur_bus,
    input  logic [mcsf_pkg::VOUT_W-1:0]        vout,
    input  logic                               out_stall,
    output logic                               room,
    output logic                               out_valid,
    output logic signed [mcsf_pkg::CUR_W-1:0]  current_u,
    output logic signed [mcsf_pkg::CUR_W-1:0]  current_v,
    output logic signed [mcsf_pkg::CUR_W-1:0]  current_bus,
    output logic [mcsf_pkg::VOUT_W-1:0]        vbus_filtered,
    output logic                               current_saturated,
    output logic                               calibration_done,
    output logic                               calibration_error
);
    import mcsf_pkg::*;

    logic                    valid_reg;
    logic signed [CUR_W-1:0] cur_u_reg;
    logic signed [CUR_W-1:0] cur_v_reg;
    logic signed [CUR_W-1:0] cur_bus_reg;
    logic [VOUT_W-1:0]       vbus_reg;
    logic                    sat_reg;
    logic                    done_reg;
    logic                    err_reg;

    // Output register may load when empty or being taken
    assign room = !valid_reg || !out_stall;

    // Hold valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (mctl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Combine lane results; a calibrate item reports no currents
    always_ff @(posedge clk)
    begin
        if (mctl.load)
        begin
            cur_u_reg   <= mctl.cmd ? '0 : cur_u;
            cur_v_reg   <= mctl.cmd ? '0 : cur_v;
            cur_bus_reg <= mctl.cmd ? '0 : cur_bus;
            sat_reg     <= !mctl.cmd && mctl.sat;
            vbus_reg    <= vout;
            done_reg    <= mctl.cal_done;
            err_reg     <= mctl.cal_done && mctl.cal_err;
        end
    end

    assign out_valid         = valid_reg;
    assign current_u         = cur_u_reg;
    assign current_v         = cur_v_reg;
    assign current_bus       = cur_bus_reg;
    assign vbus_filtered     = vbus_reg;
    assign current_saturated = sat_reg;
    assign calibration_done  = done_reg;
    assign calibration_error = err_reg;

    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        mctl.load |-> (!valid_reg || !out_stall))
        else $error("result loaded over an untaken one");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && err_reg |-> done_reg)
        else $error("window error without completed calibration");

    a_cal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && done_reg |-> cur_u_reg == '0 && cur_v_reg == '0
                                  && cur_bus_reg == '0 && !sat_reg)
        else $error("calibration item carries currents");

endmodule

// ===== rtl/motor_current_sense_frontend.sv =====
// Motor current-sense front end.
// Input channel (in_valid / in_stall): one ADC sample set per item, with a
// command bit: convert (0) or calibration sample (1). Output channel
// (out_valid / out_stall): one result item per input item, in order.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// write only while no item is in flight.
// Flow: one item is worked at a time; the sequencer steps through multiply,
// round, filter update and merge, and the result then loads into the output
// register. A new item is taken only once the sequencer is back in idle.
// The output register lets the next item start while a result waits; if the
// receiver stalls, the finished item holds in the merge step and in_stall
// stays high until the output register frees.
// Reset clears the registers to their defaults, offsets to midscale, the
// calibration sums and count and the voltage filter state.
module motor_current_sense_frontend #(
    parameter int CAL_LOG2 = 8,
    parameter int ADC_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mcsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [ADC_BITS-1:0]                 raw_phase_u,
    input  logic [ADC_BITS-1:0]                 raw_phase_v,
    input  logic [ADC_BITS-1:0]                 raw_bus_current,
    input  logic [ADC_BITS-1:0]                 raw_bus_voltage,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mcsf_pkg::CUR_W-1:0]   current_u,
    output logic signed [mcsf_pkg::CUR_W-1:0]   current_v,
    output logic signed [mcsf_pkg::CUR_W-1:0]   current_bus,
    output logic [mcsf_pkg::VOUT_W-1:0]         vbus_filtered,
    output logic                                current_saturated,
    output logic                                calibration_done,
    output logic                                calibration_error
);
    import mcsf_pkg::*;

    localparam int CNT_W       = CAL_LOG2 + 1;
    localparam int CAL_SAMPLES = 1 << CAL_LOG2;
    localparam int RCW         = (ADC_BITS > RAIL_W) ? ADC_BITS : RAIL_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL,
        PH_RND,
        PH_FILT,
        PH_OUT
    } phase_t;

    phase_t              phase_reg;
    logic [CNT_W-1:0]    cal_cnt_reg;
    logic                cal_done_reg;

    logic [GAIN_W-1:0]   current_gain_reg;
    logic [MASK_W-1:0]   sign_mask_reg;
    logic [GAIN_W-1:0]   vbus_gain_reg;
    logic [GAIN_W-1:0]   lpf_alpha_reg;
    logic [RAIL_W-1:0]   rail_low_reg;
    logic [RAIL_W-1:0]   rail_high_reg;
    logic [RAIL_W-1:0]   offset_min_reg;
    logic [RAIL_W-1:0]   offset_max_reg;

    logic                cmd_reg;
    logic [ADC_BITS-1:0] code_u_reg;
    logic [ADC_BITS-1:0] code_v_reg;
    logic [ADC_BITS-1:0] code_bus_reg;
    logic [ADC_BITS-1:0] code_vbus_reg;

    logic                in_accept;
    logic                cal_last;
    logic                room;
    logic                sat;
    ctrl_t               ctrl;
    merge_ctrl_t         mctl;
    logic signed [CUR_W-1:0] cur_u;
    logic signed [CUR_W-1:0] cur_v;
    logic signed [CUR_W-1:0] cur_bus;
    logic                err_u;
    logic                err_v;
    logic                err_bus;
    logic [VOUT_W-1:0]   vout;

    assign in_stall  = (phase_reg != PH_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cal_last  = (cal_cnt_reg == CNT_W'(CAL_SAMPLES - 1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_reg <= CURRENT_GAIN_RST;
            sign_mask_reg    <= SIGN_MASK_RST;
            vbus_gain_reg    <= VBUS_GAIN_RST;
            lpf_alpha_reg    <= LPF_ALPHA_RST;
            rail_low_reg     <= RAIL_LOW_RST;
            rail_high_reg    <= RAIL_HIGH_RST;
            offset_min_reg   <= OFFSET_MIN_RST;
            offset_max_reg   <= OFFSET_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CURRENT_GAIN: current_gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_SIGN_MASK:    sign_mask_reg    <= cfg_wdata[MASK_W-1:0];
                REG_VBUS_GAIN:    vbus_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_LPF_ALPHA:    lpf_alpha_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_RAIL_LOW:     rail_low_reg     <= cfg_wdata[RAIL_W-1:0];
                REG_RAIL_HIGH:    rail_high_reg    <= cfg_wdata[RAIL_W-1:0];
                REG_OFFSET_MIN:   offset_min_reg   <= cfg_wdata[RAIL_W-1:0];
                REG_OFFSET_MAX:   offset_max_reg   <= cfg_wdata[RAIL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg       <= command;
            code_u_reg    <= raw_phase_u;
            code_v_reg    <= raw_phase_v;
            code_bus_reg  <= raw_bus_current;
            code_vbus_reg <= raw_bus_voltage;
        end
    end

    // Sequencer and calibration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cal_cnt_reg  <= '0;
            cal_done_reg <= 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (in_accept)
                    begin
                        phase_reg <= PH_MUL;
                    end
                end
                PH_MUL:
                begin
                    phase_reg    <= PH_RND;
                    cal_done_reg <= cmd_reg && cal_last;
                    if (cmd_reg)
                    begin
                        cal_cnt_reg <= cal_last ? '0 : cal_cnt_reg + CNT_W'(1);
                    end
                end
                PH_RND:
                begin
                    phase_reg <= PH_FILT;
                end
                PH_FILT:
                begin
                    phase_reg <= PH_OUT;
                end
                PH_OUT:
                begin
                    if (room)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign ctrl.cmd      = cmd_reg;
    assign ctrl.mul      = (phase_reg == PH_MUL);
    assign ctrl.rnd      = (phase_reg == PH_RND);
    assign ctrl.filt     = (phase_reg == PH_FILT);
    assign ctrl.cal_done = cal_done_reg;

    // Rail check on the phase codes
    assign sat = (RCW'(code_u_reg) <= RCW'(rail_low_reg))
              || (RCW'(code_u_reg) >= RCW'(rail_high_reg))
              || (RCW'(code_v_reg) <= RCW'(rail_low_reg))
              || (RCW'(code_v_reg) >= RCW'(rail_high_reg));

    // Current lanes
    mcsf_cur_lane #(
        .ADC_BITS (ADC_BITS),
        .CAL_LOG2 (CAL_LOG2)
    ) u_lane_u (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .code       (code_u_reg),
        .negate     (sign_mask_reg[SIGN_U]),
        .gain       (current_gain_reg),
        .offset_min (offset_min_reg),
        .offset_max (offset_max_reg),
        .current    (cur_u),
        .win_err    (err_u)
    );

    mcsf_cur_lane #(
        .ADC_BITS (ADC_BITS),
        .CAL_LOG2 (CAL_LOG2)
    ) u_lane_v (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .code       (code_v_reg),
        .negate     (sign_mask_reg[SIGN_V]),
        .gain       (current_gain_reg),
        .offset_min (offset_min_reg),
        .offset_max (offset_max_reg),
        .current    (cur_v),
        .win_err    (err_v)
    );

    mcsf_cur_lane #(
        .ADC_BITS (ADC_BITS),
        .CAL_LOG2 (CAL_LOG2)
    ) u_lane_bus (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .code       (code_bus_reg),
        .negate     (sign_mask_reg[SIGN_BUS]),
        .gain       (current_gain_reg),
        .offset_min (offset_min_reg),
        .offset_max (offset_max_reg),
        .current    (cur_bus),
        .win_err    (err_bus)
    );

    // Bus voltage filter
    mcsf_vbus_filt #(
        .ADC_BITS (ADC_BITS)
    ) u_vbus (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .code      (code_vbus_reg),
        .vbus_gain (vbus_gain_reg),
        .lpf_alpha (lpf_alpha_reg),
        .vbus_out  (vout)
    );

    // Merge lane results into the output register
    assign mctl.load     = (phase_reg == PH_OUT) && room;
    assign mctl.cmd      = cmd_reg;
    assign mctl.cal_done = cal_done_reg;
    assign mctl.cal_err  = err_u || err_v || err_bus;
    assign mctl.sat      = sat;

    mcsf_merge u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .mctl              (mctl),
        .cur_u             (cur_u),
        .cur_v             (cur_v),
        .cur_bus           (cur_bus),
        .vout              (vout),
        .out_stall         (out_stall),
        .room              (room),
        .out_valid         (out_valid),
        .current_u         (current_u),
        .current_v         (current_v),
        .current_bus       (current_bus),
        .vbus_filtered     (vbus_filtered),
        .current_saturated (current_saturated),
        .calibration_done  (calibration_done),
        .calibration_error (calibration_error)
    );

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> phase_reg == PH_MUL)
        else $error("accepted item did not start the sequence");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_cnt_reg[CNT_W-1] == 1'b0)
        else $error("calibration count passed the run length");

    a_done_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cal_done_reg && phase_reg == PH_RND |-> cmd_reg)
        else $error("calibration completed on a convert item");

endmodule

// ===== dv/mcsf_result_checker.sv =====
`timescale 1ns / 100ps

module mcsf_result_checker #(
    parameter int CAL_LOG2 = 8,
    parameter int ADC_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mcsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                command,
    input  logic [ADC_BITS-1:0]                 raw_phase_u,
    input  logic [ADC_BITS-1:0]                 raw_phase_v,
    input  logic [ADC_BITS-1:0]                 raw_bus_current,
    input  logic [ADC_BITS-1:0]                 raw_bus_voltage,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [mcsf_pkg::CUR_W-1:0]   current_u,
    input  logic signed [mcsf_pkg::CUR_W-1:0]   current_v,
    input  logic signed [mcsf_pkg::CUR_W-1:0]   current_bus,
    input  logic [mcsf_pkg::VOUT_W-1:0]         vbus_filtered,
    input  logic                                current_saturated,
    input  logic                                calibration_done,
    input  logic                                calibration_error,
    output int                                  mismatches,
    output int                                  results_owed
);

    import mcsf_pkg::*;

    localparam logic   CMD_CALIBRATE = 1'b1;
    localparam int     CAL_RUN       = 1 << CAL_LOG2;
    localparam int     CNT_MASK      = (2 << CAL_LOG2) - 1;
    localparam longint SUM_MASK      = (longint'(1) << (ADC_BITS + CAL_LOG2)) - 1;
    localparam longint OFS_MASK      = (longint'(1) << (ADC_BITS + 4)) - 1;
    localparam longint FILT_MAX      = (longint'(1) << (ADC_BITS + 16)) - 1;

    typedef struct {
        logic signed [CUR_W-1:0] cur_u;
        logic signed [CUR_W-1:0] cur_v;
        logic signed [CUR_W-1:0] cur_bus;
        logic [VOUT_W-1:0]       vbus;
        logic                    sat;
        logic                    done;
        logic                    err;
    } sense_result_t;

    // Register copies
    longint             gain_q8;
    longint             vgain_q8;
    longint             alpha_q16;
    logic [MASK_W-1:0]  negate_mask;
    logic [RAIL_W-1:0]  rail_lo;
    logic [RAIL_W-1:0]  rail_hi;
    logic [RAIL_W-1:0]  win_lo;
    logic [RAIL_W-1:0]  win_hi;

    // Calibration and filter state
    longint ofs_u, ofs_v, ofs_b;
    longint acc_u, acc_v, acc_b;
    int     cal_seen;
    longint filt_q8;

    sense_result_t expected_results[$];
    sense_result_t want;
    sense_result_t got;
    int            fail_tally = 0;

    // Offset code to signed milliamps, rounded half up and clamped
    function automatic logic signed [CUR_W-1:0] scale_phase(input logic [ADC_BITS-1:0] code,
                                                            input longint ofs,
                                                            input logic neg);
        longint diff;
        longint amps;
        diff = code;
        diff = diff * 16 - ofs;
        if (neg)
            diff = -diff;
        amps = (diff * gain_q8 + 2048) >>> 12;
        if (amps > CUR_MAX_I)
            amps = CUR_MAX_I;
        if (amps < CUR_MIN_I)
            amps = CUR_MIN_I;
        return amps[CUR_W-1:0];
    endfunction

    function automatic longint offset_average(input longint acc);
        longint q4;
        q4 = acc * 16;
        if (CAL_LOG2 > 0)
            q4 += (longint'(1) << CAL_LOG2) >> 1;
        return (q4 >> CAL_LOG2) & OFS_MASK;
    endfunction

    function automatic logic outside_window(input longint ofs);
        longint lo_q4;
        longint hi_q4;
        lo_q4 = win_lo;
        hi_q4 = win_hi;
        return (ofs < lo_q4 * 16) || (ofs > hi_q4 * 16);
    endfunction

    function automatic logic [VOUT_W-1:0] filtered_mv();
        longint mv;
        mv = (filt_q8 + 128) >>> 8;
        if (mv > VOUT_MAX_I)
            mv = VOUT_MAX_I;
        return mv[VOUT_W-1:0];
    endfunction

    // Work out the result of one sample set and advance the state
    function automatic sense_result_t predict_sense(input logic cmd,
                                                    input logic [ADC_BITS-1:0] u,
                                                    input logic [ADC_BITS-1:0] v,
                                                    input logic [ADC_BITS-1:0] b,
                                                    input logic [ADC_BITS-1:0] vb);
        sense_result_t r;
        longint        x;
        longint        s;
        r = '{default: '0};
        if (cmd == CMD_CALIBRATE)
        begin
            acc_u = (acc_u + u) & SUM_MASK;
            acc_v = (acc_v + v) & SUM_MASK;
            acc_b = (acc_b + b) & SUM_MASK;
            cal_seen = (cal_seen + 1) & CNT_MASK;
            if (cal_seen >= CAL_RUN)
            begin
                ofs_u = offset_average(acc_u);
                ofs_v = offset_average(acc_v);
                ofs_b = offset_average(acc_b);
                r.done = 1'b1;
                r.err = outside_window(ofs_u) || outside_window(ofs_v) ||
                        outside_window(ofs_b);
                acc_u = 0;
                acc_v = 0;
                acc_b = 0;
                cal_seen = 0;
            end
            r.vbus = filtered_mv();
            return r;
        end
        r.cur_u = scale_phase(u, ofs_u, negate_mask[SIGN_U]);
        r.cur_v = scale_phase(v, ofs_v, negate_mask[SIGN_V]);
        r.cur_bus = scale_phase(b, ofs_b, negate_mask[SIGN_BUS]);
        r.sat = (u <= rail_lo) || (u >= rail_hi) || (v <= rail_lo) || (v >= rail_hi);
        // step the low-pass filter towards the scaled voltage
        x = vb;
        x = x * vgain_q8;
        s = filt_q8 + (((x - filt_q8) * alpha_q16 + 32768) >>> 16);
        if (s < 0)
            s = 0;
        if (s > FILT_MAX)
            s = FILT_MAX;
        filt_q8 = s;
        r.vbus = filtered_mv();
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [63:0] exp_val,
                                 input logic signed [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // restore register defaults, midscale offsets and empty sums
            gain_q8 = CURRENT_GAIN_RST;
            negate_mask = SIGN_MASK_RST;
            vgain_q8 = VBUS_GAIN_RST;
            alpha_q16 = LPF_ALPHA_RST;
            rail_lo = RAIL_LOW_RST;
            rail_hi = RAIL_HIGH_RST;
            win_lo = OFFSET_MIN_RST;
            win_hi = OFFSET_MAX_RST;
            ofs_u = MIDSCALE_Q4 & OFS_MASK;
            ofs_v = MIDSCALE_Q4 & OFS_MASK;
            ofs_b = MIDSCALE_Q4 & OFS_MASK;
            acc_u = 0;
            acc_v = 0;
            acc_b = 0;
            cal_seen = 0;
            filt_q8 = 0;
            expected_results.delete();
            results_owed <= 0;
            mismatches <= fail_tally;
        end
        else
        begin
            // take register writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CURRENT_GAIN: gain_q8 = cfg_wdata;
                    REG_SIGN_MASK:    negate_mask = cfg_wdata[MASK_W-1:0];
                    REG_VBUS_GAIN:    vgain_q8 = cfg_wdata;
                    REG_LPF_ALPHA:    alpha_q16 = cfg_wdata;
                    REG_RAIL_LOW:     rail_lo = cfg_wdata[RAIL_W-1:0];
                    REG_RAIL_HIGH:    rail_hi = cfg_wdata[RAIL_W-1:0];
                    REG_OFFSET_MIN:   win_lo = cfg_wdata[RAIL_W-1:0];
                    REG_OFFSET_MAX:   win_hi = cfg_wdata[RAIL_W-1:0];
                    default: ;
                endcase
            end

            // retire the oldest expectation against a delivered item
            if (out_valid && !out_stall)
            begin
                got.cur_u = current_u;
                got.cur_v = current_v;
                got.cur_bus = current_bus;
                got.vbus = vbus_filtered;
                got.sat = current_saturated;
                got.done = calibration_done;
                got.err = calibration_error;
                if (expected_results.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    fail_tally++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("current_u", want.cur_u, got.cur_u);
                    compare_field("current_v", want.cur_v, got.cur_v);
                    compare_field("current_bus", want.cur_bus, got.cur_bus);
                    compare_field("vbus_filtered", want.vbus, got.vbus);
                    compare_field("current_saturated", want.sat, got.sat);
                    compare_field("calibration_done", want.done, got.done);
                    compare_field("calibration_error", want.err, got.err);
                end
            end

            // queue the prediction for an accepted item
            if (in_valid && !in_stall)
                expected_results.push_back(predict_sense(command, raw_phase_u, raw_phase_v,
                                                         raw_bus_current, raw_bus_voltage));

            results_owed <= expected_results.size();
            mismatches <= fail_tally;
        end
    end

endmodule

// ===== dv/motor_current_sense_frontend_test.sv =====
`timescale 1ns / 100ps

module motor_current_sense_frontend_test;

    import mcsf_pkg::*;

    localparam int   CAL_LOG2      = 8;
    localparam int   ADC_BITS      = 12;
    localparam int   CAL_RUN       = 1 << CAL_LOG2;
    localparam int   STUCK_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 12;
    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    typedef enum int {
        FLOW_FREE,
        FLOW_COIN,
        FLOW_CHOKED,
        FLOW_PERIODIC
    } flow_mode_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    cfg_reg_t                       cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_wdata;
    logic                           in_valid;
    logic                           in_stall;
    logic                           command;
    logic [ADC_BITS-1:0]            raw_phase_u;
    logic [ADC_BITS-1:0]            raw_phase_v;
    logic [ADC_BITS-1:0]            raw_bus_current;
    logic [ADC_BITS-1:0]            raw_bus_voltage;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [CUR_W-1:0]        current_u;
    logic signed [CUR_W-1:0]        current_v;
    logic signed [CUR_W-1:0]        current_bus;
    logic [VOUT_W-1:0]              vbus_filtered;
    logic                           current_saturated;
    logic                           calibration_done;
    logic                           calibration_error;

    int                             mismatches;
    int                             results_owed;

    int                             burst_left = 0;
    int                             cal_sent = 0;
    logic [RAIL_W-1:0]              rail_lo_now = RAIL_LOW_RST;
    logic [RAIL_W-1:0]              rail_hi_now = RAIL_HIGH_RST;

    flow_mode_t                     flow_mode = FLOW_FREE;
    int                             flow_left = 0;
    int                             flow_tick = 0;

    motor_current_sense_frontend #(
        .CAL_LOG2 (CAL_LOG2),
        .ADC_BITS (ADC_BITS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .raw_phase_u       (raw_phase_u),
        .raw_phase_v       (raw_phase_v),
        .raw_bus_current   (raw_bus_current),
        .raw_bus_voltage   (raw_bus_voltage),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .current_u         (current_u),
        .current_v         (current_v),
        .current_bus       (current_bus),
        .vbus_filtered     (vbus_filtered),
        .current_saturated (current_saturated),
        .calibration_done  (calibration_done),
        .calibration_error (calibration_error)
    );

    mcsf_result_checker #(
        .CAL_LOG2 (CAL_LOG2),
        .ADC_BITS (ADC_BITS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .raw_phase_u       (raw_phase_u),
        .raw_phase_v       (raw_phase_v),
        .raw_bus_current   (raw_bus_current),
        .raw_bus_voltage   (raw_bus_voltage),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .current_u         (current_u),
        .current_v         (current_v),
        .current_bus       (current_bus),
        .vbus_filtered     (vbus_filtered),
        .current_saturated (current_saturated),
        .calibration_done  (calibration_done),
        .calibration_error (calibration_error),
        .mismatches        (mismatches),
        .results_owed      (results_owed)
    );

    always #1 clk = ~clk;

    // Receiver: switch between free flow, coin-toss, heavy and periodic stalling
    always @(posedge clk)
    begin
        if (flow_left == 0)
        begin
            flow_mode = flow_mode_t'($urandom_range(3, 0));
            flow_left = $urandom_range(48, 8);
        end
        flow_left--;
        flow_tick++;
        case (flow_mode)
            FLOW_FREE:   out_stall <= 1'b0;
            FLOW_COIN:   out_stall <= ($urandom_range(1, 0) == 1);
            FLOW_CHOKED: out_stall <= ($urandom_range(4, 0) != 0);
            default:     out_stall <= ((flow_tick % 6) < 2);
        endcase
    end

    // Present one item and hold it until accepted; open bursts with a random gap
    task automatic send_item(input logic cmd, input logic [ADC_BITS-1:0] u,
                             input logic [ADC_BITS-1:0] v, input logic [ADC_BITS-1:0] b,
                             input logic [ADC_BITS-1:0] vb);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            burst_left = $urandom_range(16, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        command <= cmd;
        raw_phase_u <= u;
        raw_phase_v <= v;
        raw_bus_current <= b;
        raw_bus_voltage <= vb;
        in_valid <= 1'b1;
        burst_left--;
        if (cmd == CMD_CALIBRATE)
            cal_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Favour rail edges and full-scale codes over plain random ones
    function automatic logic [ADC_BITS-1:0] pick_code();
        case ($urandom_range(9, 0))
            0:       return rail_lo_now;
            1:       return rail_lo_now + 1'b1;
            2:       return rail_hi_now;
            3:       return rail_hi_now - 1'b1;
            4:       return ($urandom_range(1, 0) == 1) ? '1 : '0;
            default: return $urandom_range(4095, 0);
        endcase
    endfunction

    function automatic logic [ADC_BITS-1:0] cal_code(input int centre, input int spread);
        int lo;
        int hi;
        lo = (centre - spread < 0) ? 0 : centre - spread;
        hi = (centre + spread > 4095) ? 4095 : centre + spread;
        return $urandom_range(hi, lo);
    endfunction

    task automatic random_convert();
        send_item(CMD_CONVERT, pick_code(), pick_code(), pick_code(),
                  $urandom_range(4095, 0));
    endtask

    // Finish the current calibration run with convert items mixed in
    task automatic calibration_run(input int cu, input int cv, input int cb, input int spread);
        int target;
        target = (cal_sent / CAL_RUN + 1) * CAL_RUN;
        while (cal_sent < target)
        begin
            if ($urandom_range(7, 0) == 0)
                random_convert();
            else
                send_item(CMD_CALIBRATE, cal_code(cu, spread), cal_code(cv, spread),
                          cal_code(cb, spread), $urandom_range(4095, 0));
        end
    endtask

    // Drop valid and wait until every expected result has been delivered
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_frontend(input logic [15:0] gain, input logic [2:0] negate,
                                    input logic [15:0] vgain, input logic [15:0] alpha,
                                    input logic [11:0] rlo, input logic [11:0] rhi,
                                    input logic [11:0] wlo, input logic [11:0] whi);
        write_register(REG_CURRENT_GAIN, gain);
        write_register(REG_SIGN_MASK, {13'd0, negate});
        write_register(REG_VBUS_GAIN, vgain);
        write_register(REG_LPF_ALPHA, alpha);
        write_register(REG_RAIL_LOW, {4'd0, rlo});
        write_register(REG_RAIL_HIGH, {4'd0, rhi});
        write_register(REG_OFFSET_MIN, {4'd0, wlo});
        write_register(REG_OFFSET_MAX, {4'd0, whi});
        cfg_we <= 1'b0;
        rail_lo_now = rlo;
        rail_hi_now = rhi;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CURRENT_GAIN;
        cfg_wdata = '0;
        in_valid = 1'b0;
        command = CMD_CONVERT;
        raw_phase_u = '0;
        raw_phase_v = '0;
        raw_bus_current = '0;
        raw_bus_voltage = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: full scale, rail edges, partial calibration then convert
        send_item(CMD_CONVERT, 12'd0, 12'd0, 12'd0, 12'd0);
        send_item(CMD_CONVERT, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_item(CMD_CONVERT, 12'd16, 12'd17, 12'd2048, 12'd4095);
        send_item(CMD_CONVERT, 12'd17, 12'd16, 12'd2047, 12'd4095);
        send_item(CMD_CONVERT, 12'd4079, 12'd2048, 12'd2049, 12'd2048);
        send_item(CMD_CONVERT, 12'd2048, 12'd4078, 12'd1, 12'd0);
        send_item(CMD_CONVERT, 12'd4078, 12'd4079, 12'd4094, 12'd1);
        send_item(CMD_CONVERT, 12'd2048, 12'd2048, 12'd2048, 12'd3000);
        send_item(CMD_CALIBRATE, 12'd2000, 12'd2100, 12'd1900, 12'd4095);
        send_item(CMD_CALIBRATE, 12'd4095, 12'd4095, 12'd4095, 12'd0);
        send_item(CMD_CALIBRATE, 12'd0, 12'd0, 12'd0, 12'd1234);
        send_item(CMD_CONVERT, 12'd2048, 12'd2048, 12'd2048, 12'd4095);
        wait_for_quiet();

        // Largest gains, all channels negated, fastest filter, widest rails
        program_frontend(16'hFFFF, 3'b111, 16'hFFFF, 16'hFFFF, 12'd0, 12'd4095, 12'd0, 12'd4095);
        send_item(CMD_CONVERT, 12'd0, 12'd4095, 12'd0, 12'd4095);
        send_item(CMD_CONVERT, 12'd4095, 12'd0, 12'd4095, 12'd4095);
        send_item(CMD_CONVERT, 12'd1, 12'd4094, 12'd2048, 12'd0);
        repeat (40) random_convert();
        wait_for_quiet();

        // Random gains, window around midscale: a run that should pass
        program_frontend($urandom_range(65535, 0), $urandom_range(7, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(300, 0), $urandom_range(4095, 3800),
                         $urandom_range(2040, 1500), $urandom_range(2600, 2060));
        calibration_run(2048, 2048, 2048, 40);
        repeat (10) random_convert();
        wait_for_quiet();

        // Zero gains, frozen filter, inverted rails and window
        program_frontend(16'd0, 3'b000, 16'd0, 16'd0, 12'd4095, 12'd0, 12'd4095, 12'd0);
        repeat (24) random_convert();
        repeat (5)
            send_item(CMD_CALIBRATE, pick_code(), pick_code(), pick_code(),
                      $urandom_range(4095, 0));
        wait_for_quiet();

        // Inverted window with lopsided codes: a run that must flag an error
        program_frontend($urandom_range(65535, 0), $urandom_range(7, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(300, 0), $urandom_range(4095, 3800),
                         $urandom_range(4095, 2500), $urandom_range(1500, 0));
        calibration_run(4000, 2048, 100, 95);
        repeat (10) random_convert();
        wait_for_quiet();

        // Fully random registers, converts with stray calibration items
        program_frontend($urandom_range(65535, 0), $urandom_range(7, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(4095, 0), $urandom_range(4095, 0),
                         $urandom_range(4095, 0), $urandom_range(4095, 0));
        repeat (40)
        begin
            if ($urandom_range(9, 0) == 0)
                send_item(CMD_CALIBRATE, pick_code(), pick_code(), pick_code(),
                          $urandom_range(4095, 0));
            else
                random_convert();
        end
        wait_for_quiet();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_owed == 0)
            $display("motor_current_sense_frontend verification clean");
        else
            $display("motor_current_sense_frontend verification failed");
        $finish;
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("motor_current_sense_frontend verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mcsf_pkg.sv
rtl/mcsf_cur_lane.sv
rtl/mcsf_vbus_filt.sv
rtl/mcsf_merge.sv
rtl/motor_current_sense_frontend.sv
dv/mcsf_result_checker.sv
dv/motor_current_sense_frontend_test.sv
